/* rtl/multi_timer_bank_defines.svh */
// Assertion macros shared by the timer bank RTL.
`ifndef MULTI_TIMER_BANK_DEFINES_SVH
`define MULTI_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define MTB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// Next-cycle implication, checked on clk outside reset.
`define MTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

/* rtl/mtb_pkg.sv */
// Types, codes and constants for the timer bank.
package mtb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int ACT_W  = 4;
  localparam int DIV_W  = 8;
  localparam int MS_W   = 16;
  localparam int RUNS_W = 8;
  localparam int MASK_W = 8;
  localparam int KIND_W = 3;
  localparam int TI_W   = 3;

  localparam logic [RUNS_W-1:0] RUNS_ENDLESS = 8'hFF;
  localparam logic [RUNS_W-1:0] RUNS_ONE     = 8'h01;

  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ONCE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMES   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CYCLIC  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COLLECT = 3'd5;

  localparam logic REG_ACTIVE  = 1'b0;
  localparam logic REG_DIVIDER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } mtb_state_t;

  typedef struct packed {
    logic clear_all;
    logic load;
    logic update;
    logic collect;
  } mtb_ctl_t;

endpackage

/* rtl/mtb_update.sv */
// Shared countdown unit: one timer's next count, runs and expiry per use.
module mtb_update import mtb_pkg::*; (
  input  logic [MS_W-1:0]   remaining,
  input  logic [MS_W-1:0]   reload,
  input  logic [RUNS_W-1:0] runs,
  input  logic [DIV_W-1:0]  divider,
  output logic [MS_W-1:0]   remaining_next,
  output logic [RUNS_W-1:0] runs_next,
  output logic              expired
);

  logic [MS_W-1:0] div_ext;

  assign div_ext = MS_W'(divider);

  always_comb begin
    remaining_next = remaining;
    runs_next      = runs;
    expired        = 1'b0;
    if (runs != '0) begin
      if (remaining > div_ext) begin
        remaining_next = remaining - div_ext;
      end else begin
        remaining_next = reload;
        expired        = 1'b1;
        if (runs != RUNS_ENDLESS) runs_next = runs - RUNS_ONE;
        // one-shot timers stop at expiry
        if (reload == '0) runs_next = '0;
      end
    end
  end

endmodule

/* rtl/mtb_store.sv */
// Per-timer state: counts, reloads, run counts and timeout flags.
module mtb_store import mtb_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mtb_ctl_t              ctl,
  input  logic [IDX_W-1:0]      load_idx,
  input  logic [MS_W-1:0]       load_rem,
  input  logic [MS_W-1:0]       load_rel,
  input  logic [RUNS_W-1:0]     load_runs,
  input  logic [IDX_W-1:0]      upd_idx,
  input  logic [MS_W-1:0]       upd_rem,
  input  logic [RUNS_W-1:0]     upd_runs,
  input  logic                  upd_expired,
  input  logic [NUM_TIMERS-1:0] live_vec,
  output logic [MS_W-1:0]       rd_rem,
  output logic [MS_W-1:0]       rd_rel,
  output logic [RUNS_W-1:0]     rd_runs,
  output logic [NUM_TIMERS-1:0] flags,
  output logic [NUM_TIMERS-1:0] running
);

  logic [MS_W-1:0]   rem  [NUM_TIMERS];
  logic [MS_W-1:0]   rel  [NUM_TIMERS];
  logic [RUNS_W-1:0] runs [NUM_TIMERS];

  assign rd_rem  = rem[upd_idx];
  assign rd_rel  = rel[upd_idx];
  assign rd_runs = runs[upd_idx];

  always_comb begin
    for (int t = 0; t < NUM_TIMERS; t++) running[t] = (runs[t] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        rem[t]  <= '0;
        rel[t]  <= '0;
        runs[t] <= '0;
      end
      flags <= '0;
    end else begin
      if (ctl.load) begin
        rem[load_idx]   <= load_rem;
        rel[load_idx]   <= load_rel;
        runs[load_idx]  <= load_runs;
        flags[load_idx] <= 1'b0;
      end
      if (ctl.update) begin
        rem[upd_idx]  <= upd_rem;
        runs[upd_idx] <= upd_runs;
        if (upd_expired) flags[upd_idx] <= 1'b1;
      end
      // drop flags of the timers in use only
      if (ctl.collect) flags <= flags & ~live_vec;
    end
  end

endmodule

/* rtl/multi_timer_bank.sv */
// Timer bank top level: command sequencer, prescaler and result register.
// Usage:
//   Commands arrive on the input channel (in_valid / in_ready) as kind,
//   timer_index, period_ms and repeat_times. Each command yields exactly one
//   result on the output channel (out_valid / out_ready): timeout_mask,
//   running_mask and status.
//   A tick that rolls the prescaler over walks the active timers (at most
//   NUM_TIMERS) through one shared countdown unit, one timer per cycle, in
//   the scan state before its result is loaded; every other command, and a
//   tick with no active timer, goes from the transfer straight to the result
//   stage. The next command is taken in the cycle after the result is loaded.
//   The result register holds until the receiver takes it; the bank then
//   waits with the next result ready until the output is free, and does not
//   take a new command until that result is loaded.
//   active_timers and tick_divider are written through cfg_we, cfg_index and
//   cfg_data, by the user only while the bank is idle; the bank does not enforce it.
//   Synchronous reset stops all timers, clears counts, flags and the
//   prescaler, and sets active_timers to 0 and tick_divider to 1.
`include "multi_timer_bank_defines.svh"

module multi_timer_bank import mtb_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DIV_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [TI_W-1:0]   timer_index,
  input  logic [MS_W-1:0]   period_ms,
  input  logic [RUNS_W-1:0] repeat_times,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] timeout_mask,
  output logic [MASK_W-1:0] running_mask,
  output logic              status
);

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int LIVE_W = $clog2(NUM_TIMERS + 1);
  localparam int CW     = (LIVE_W > ACT_W) ? LIVE_W : ACT_W;

  logic [ACT_W-1:0]  active_timers;
  logic [DIV_W-1:0]  tick_divider;
  logic [DIV_W-1:0]  prescale, prescale_next;
  mtb_state_t        state, state_next;
  logic [LIVE_W-1:0] scan_idx, scan_idx_next, scan_inc;
  logic [KIND_W-1:0] kind_q;
  logic              status_q, status_next;

  logic [CW-1:0]         live_cw, ti_cw;
  logic [LIVE_W-1:0]     live;
  logic [NUM_TIMERS-1:0] live_vec;
  logic                  is_start, start_ok, finish;
  mtb_ctl_t              ctl;
  logic [MS_W-1:0]       load_rel;
  logic [RUNS_W-1:0]     load_runs;
  logic [DIV_W-1:0]      pc_inc;

  logic [MS_W-1:0]       rd_rem, rd_rel, upd_rem;
  logic [RUNS_W-1:0]     rd_runs, upd_runs;
  logic                  upd_expired;
  logic [NUM_TIMERS-1:0] flags, running;
  logic [MASK_W-1:0]     tmask, rmask;

  // clamp the active count to the bank size
  assign live_cw = (CW'(active_timers) > CW'(NUM_TIMERS)) ? CW'(NUM_TIMERS)
                                                          : CW'(active_timers);
  assign live    = live_cw[LIVE_W-1:0];
  assign ti_cw   = CW'(timer_index);
  assign scan_inc = scan_idx + LIVE_W'(1);
  assign pc_inc  = prescale + DIV_W'(1);

  always_comb begin
    for (int t = 0; t < NUM_TIMERS; t++) live_vec[t] = (LIVE_W'(t) < live);
  end

  assign is_start = (kind == KIND_ONCE) || (kind == KIND_TIMES) || (kind == KIND_CYCLIC);
  assign start_ok = is_start && (ti_cw < live_cw);
  assign load_rel = (kind == KIND_ONCE) ? '0 : period_ms;

  always_comb begin
    case (kind)
      KIND_ONCE:   load_runs = RUNS_ONE;
      KIND_TIMES:  load_runs = repeat_times;
      default:     load_runs = RUNS_ENDLESS;
    endcase
  end

  assign in_ready = (state == ST_IDLE);
  assign finish   = (state == ST_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    prescale_next = prescale;
    status_next   = status_q;
    ctl           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          status_next   = is_start && !start_ok;
          ctl.load      = start_ok;
          ctl.clear_all = (kind == KIND_CLEAR);
          scan_idx_next = '0;
          state_next    = ST_FINISH;
          if (kind == KIND_TICK) begin
            if (pc_inc < tick_divider) begin
              prescale_next = pc_inc;
            end else begin
              prescale_next = '0;
              if (live != '0) state_next = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        ctl.update    = 1'b1;
        scan_idx_next = scan_inc;
        if (scan_inc == live) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish) begin
          ctl.collect = (kind_q == KIND_COLLECT);
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan_idx      <= '0;
      prescale      <= '0;
      active_timers <= '0;
      tick_divider  <= DIV_W'(1);
      status_q      <= 1'b0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      prescale <= prescale_next;
      status_q <= status_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE:  active_timers <= cfg_data[ACT_W-1:0];
          REG_DIVIDER: tick_divider  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) kind_q <= kind;
  end

  mtb_update u_update (
    .remaining      (rd_rem),
    .reload         (rd_rel),
    .runs           (rd_runs),
    .divider        (tick_divider),
    .remaining_next (upd_rem),
    .runs_next      (upd_runs),
    .expired        (upd_expired)
  );

  mtb_store #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .load_idx    (ti_cw[IDX_W-1:0]),
    .load_rem    (period_ms),
    .load_rel    (load_rel),
    .load_runs   (load_runs),
    .upd_idx     (scan_idx[IDX_W-1:0]),
    .upd_rem     (upd_rem),
    .upd_runs    (upd_runs),
    .upd_expired (upd_expired),
    .live_vec    (live_vec),
    .rd_rem      (rd_rem),
    .rd_rel      (rd_rel),
    .rd_runs     (rd_runs),
    .flags       (flags),
    .running     (running)
  );

  // masks show only active timers among the low eight
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < NUM_TIMERS) begin : g_used
      assign tmask[g] = flags[g] & live_vec[g];
      assign rmask[g] = running[g] & live_vec[g];
    end else begin : g_unused
      assign tmask[g] = 1'b0;
      assign rmask[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      timeout_mask <= tmask;
      running_mask <= rmask;
      status       <= status_q;
    end
  end

  `MTB_ASSERT_NOW(a_scan_in_range, state == ST_SCAN, scan_idx < live)
  `MTB_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state != ST_IDLE)
  `MTB_ASSERT_NEXT(a_finish_waits, state == ST_FINISH && out_valid && !out_ready,
                   state == ST_FINISH)
  `MTB_ASSERT_NEXT(a_clear_stops, ctl.clear_all, running == '0 && flags == '0)

endmodule

/* dv/multi_timer_bank_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the timer bank: directed and random command streams.
module multi_timer_bank_test;
  import mtb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int BANK_SIZE     = NUM_TIMERS_DEF;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [KIND_W-1:0] op;
    logic [TI_W-1:0]   index;
    logic [MS_W-1:0]   period;
    logic [RUNS_W-1:0] runs;
  } timer_cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] timeout_mask;
    logic [MASK_W-1:0] running_mask;
    logic              status;
  } bank_view_t;

  typedef enum {RX_STREAM, RX_COIN, RX_SPARSE} rx_pattern_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_ACTIVE;
  logic [DIV_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind = KIND_TICK;
  logic [TI_W-1:0]   timer_index = '0;
  logic [MS_W-1:0]   period_ms = '0;
  logic [RUNS_W-1:0] repeat_times = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] timeout_mask;
  logic [MASK_W-1:0] running_mask;
  logic              status;

  multi_timer_bank dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .timer_index(timer_index), .period_ms(period_ms),
    .repeat_times(repeat_times),
    .out_valid(out_valid), .out_ready(out_ready),
    .timeout_mask(timeout_mask), .running_mask(running_mask), .status(status)
  );

  always #6 clk = ~clk;

  // Shadow copy of the bank
  logic [ACT_W-1:0]     bank_active = '0;
  logic [DIV_W-1:0]     bank_divider = 8'd1;
  logic [DIV_W-1:0]     bank_prescale = '0;
  logic [MS_W-1:0]      bank_remain [BANK_SIZE];
  logic [MS_W-1:0]      bank_reload [BANK_SIZE];
  logic [RUNS_W-1:0]    bank_runs [BANK_SIZE];
  logic [BANK_SIZE-1:0] bank_flags;

  bank_view_t expected_views[$];
  int error_count = 0;
  int burst_left = 0;

  function automatic int live_timers();
    return (bank_active > BANK_SIZE) ? BANK_SIZE : int'(bank_active);
  endfunction

  function automatic void clear_bank_state();
    for (int t = 0; t < BANK_SIZE; t++) begin
      bank_remain[t] = '0;
      bank_reload[t] = '0;
      bank_runs[t]   = '0;
    end
    bank_flags = '0;
  endfunction

  function automatic void load_timer(int t, logic [MS_W-1:0] count,
                                     logic [MS_W-1:0] reload, logic [RUNS_W-1:0] runs);
    bank_flags[t]  = 1'b0;
    bank_remain[t] = count;
    bank_reload[t] = reload;
    bank_runs[t]   = runs;
  endfunction

  // Apply one command to the shadow bank and return the result it should produce.
  function automatic bank_view_t apply_timer_cmd(timer_cmd_t c);
    bank_view_t v;
    int n;
    n = live_timers();
    v = '0;
    if (c.op inside {KIND_ONCE, KIND_TIMES, KIND_CYCLIC} && int'(c.index) >= n) begin
      v.status = 1'b1;
    end else begin
      case (c.op)
        KIND_TICK: begin
          bank_prescale = bank_prescale + 1'b1;
          if (bank_prescale >= bank_divider) begin
            bank_prescale = '0;
            for (int t = 0; t < n; t++) begin
              if (bank_runs[t] != '0) begin
                if (bank_remain[t] > MS_W'(bank_divider)) begin
                  bank_remain[t] = bank_remain[t] - MS_W'(bank_divider);
                end else begin
                  // expire: reload, use up a run, stop on a zero reload
                  bank_remain[t] = bank_reload[t];
                  if (bank_runs[t] != RUNS_ENDLESS) bank_runs[t] = bank_runs[t] - 1'b1;
                  if (bank_reload[t] == '0) bank_runs[t] = '0;
                  bank_flags[t] = 1'b1;
                end
              end
            end
          end
        end
        KIND_CLEAR:  clear_bank_state();
        KIND_ONCE:   load_timer(int'(c.index), c.period, '0, RUNS_ONE);
        KIND_TIMES:  load_timer(int'(c.index), c.period, c.period, c.runs);
        KIND_CYCLIC: load_timer(int'(c.index), c.period, c.period, RUNS_ENDLESS);
        default: ;
      endcase
    end
    for (int t = 0; t < n && t < MASK_W; t++) begin
      v.timeout_mask[t] = bank_flags[t];
      v.running_mask[t] = (bank_runs[t] != '0);
    end
    if (c.op == KIND_COLLECT) begin
      for (int t = 0; t < n; t++) bank_flags[t] = 1'b0;
    end
    return v;
  endfunction

  task automatic send_cmd(input logic [KIND_W-1:0] op, input logic [TI_W-1:0] index,
                          input logic [MS_W-1:0] period, input logic [RUNS_W-1:0] runs);
    int gap;
    timer_cmd_t c;
    // open a new burst, sometimes after an idle gap
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    kind         <= op;
    timer_index  <= index;
    period_ms    <= period;
    repeat_times <= runs;
    do @(posedge clk); while (!in_ready);
    c.op     = op;
    c.index  = index;
    c.period = period;
    c.runs   = runs;
    expected_views.push_back(apply_timer_cmd(c));
  endtask

  // Hold off new commands until every pending result has come back.
  task automatic drain_bank();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
    burst_left = 0;
  endtask

  task automatic set_config(input logic [ACT_W-1:0] active, input logic [DIV_W-1:0] divider);
    drain_bank();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACTIVE;
    cfg_data  <= DIV_W'(active);
    @(posedge clk);
    bank_active = active;
    cfg_index <= REG_DIVIDER;
    cfg_data  <= divider;
    @(posedge clk);
    bank_divider = divider;
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int items, input int tick_pct, input int span);
    logic [KIND_W-1:0] op;
    logic [TI_W-1:0]   index;
    logic [MS_W-1:0]   period;
    logic [RUNS_W-1:0] runs;
    int pick;
    int n;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
        op = KIND_TICK;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 14)      op = KIND_ONCE;
        else if (pick < 40) op = KIND_TIMES;
        else if (pick < 55) op = KIND_CYCLIC;
        else if (pick < 82) op = KIND_COLLECT;
        else if (pick < 90) op = KIND_CLEAR;
        else if (pick < 95) op = KIND_SPARE_LO;
        else                op = KIND_SPARE_HI;
      end
      // aim most starts at live timers
      n = live_timers();
      if (n > 0 && $urandom_range(0, 3) != 0) index = TI_W'($urandom_range(0, n - 1));
      else index = TI_W'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       period = MS_W'($urandom_range(0, 16'hFFFF));
        1:       period = 16'hFFFF;
        2:       period = '0;
        default: period = MS_W'($urandom_range(0, span));
      endcase
      case ($urandom_range(0, 7))
        0:       runs = RUNS_W'($urandom_range(0, 8'hFF));
        1:       runs = RUNS_ENDLESS;
        default: runs = RUNS_W'($urandom_range(0, 4));
      endcase
      send_cmd(op, index, period, runs);
      if ($urandom_range(0, 49) == 0) drain_bank();
    end
  endtask

  task automatic test_after_reset();
    send_cmd(KIND_TICK, 0, 0, 0);
    send_cmd(KIND_ONCE, 0, 3, 0);
    send_cmd(KIND_COLLECT, 0, 0, 0);
  endtask

  task automatic test_start_kinds();
    set_config(4'd8, 8'd1);
    send_cmd(KIND_ONCE, 0, 0, 0);
    send_cmd(KIND_TIMES, 1, 2, 2);
    send_cmd(KIND_TIMES, 2, 5, 0);
    send_cmd(KIND_CYCLIC, 7, 16'hFFFF, 0);
    send_cmd(KIND_TIMES, 3, 1, RUNS_ENDLESS);
    repeat (3) send_cmd(KIND_TICK, 0, 0, 0);
    repeat (2) send_cmd(KIND_COLLECT, 0, 0, 0);
    send_cmd(KIND_SPARE_LO, 7, 16'hFFFF, 8'hFF);
    send_cmd(KIND_SPARE_HI, 5, 16'h5555, 8'hAA);
    send_cmd(KIND_CLEAR, 0, 0, 0);
  endtask

  task automatic test_bank_limits();
    // zero divider updates on every tick; index 3 is past the live count
    set_config(4'd3, 8'd0);
    send_cmd(KIND_CYCLIC, 2, 0, 0);
    send_cmd(KIND_ONCE, 3, 9, 1);
    send_cmd(KIND_TIMES, 0, 7, 1);
    send_cmd(KIND_TICK, 0, 0, 0);
    send_cmd(KIND_TICK, 0, 0, 0);
    send_cmd(KIND_COLLECT, 0, 0, 0);
    // an oversized active count acts as the full bank
    set_config(4'd15, 8'd255);
    send_cmd(KIND_ONCE, 7, 16'hFFFF, 0);
    send_cmd(KIND_TICK, 0, 0, 0);
    send_cmd(KIND_COLLECT, 0, 0, 0);
  endtask

  task automatic test_random_traffic();
    logic [ACT_W-1:0] active;
    logic [DIV_W-1:0] divider;
    for (int phase = 0; phase < 8; phase++) begin
      active  = ($urandom_range(0, 4) == 0) ? ACT_W'($urandom_range(0, 15))
                                            : ACT_W'($urandom_range(1, 8));
      divider = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
      set_config(active, divider);
      random_traffic(32, 50, 4 * int'(divider) + 6);
    end
  endtask

  task automatic test_slow_prescaler();
    // enough ticks to roll a full-scale prescaler at least once
    set_config(4'd8, 8'd255);
    random_traffic(280, 95, 700);
  endtask

  always @(posedge clk) begin : check_results
    bank_view_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        $error("unexpected result: timeout_mask %02h running_mask %02h status %0d",
               timeout_mask, running_mask, status);
        error_count++;
      end else begin
        want = expected_views.pop_front();
        if (timeout_mask !== want.timeout_mask) begin
          $error("timeout_mask: expected %02h, got %02h", want.timeout_mask, timeout_mask);
          error_count++;
        end
        if (running_mask !== want.running_mask) begin
          $error("running_mask: expected %02h, got %02h", want.running_mask, running_mask);
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
      end
    end
  end

  rx_pattern_t rx_pattern = RX_STREAM;
  int rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 2));
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_pattern)
      RX_STREAM: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_bank_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_start_kinds();
    test_bank_limits();
    test_random_traffic();
    test_slow_prescaler();
    drain_bank();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
